@@ hdl/bpde_pkg.sv @@
// shared types, codes and constants of the bitmap drawing engine
`default_nettype none
package bpde_pkg;

  localparam int CANVAS_ROWS_DEF = 32;
  localparam int CANVAS_COLS_DEF = 32;

  localparam int CMD_W      = 3;
  localparam int COORD_W    = 5;
  localparam int SIZE_W     = 6;
  localparam int ROW_IDX_W  = 5;
  localparam int ROW_BITS_W = 32;
  localparam int EXT_W      = 10;
  localparam int DX_W       = 6;
  localparam int LIM_W      = 2 * SIZE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECT         = 3'd0,
    CMD_LINE         = 3'd1,
    CMD_TRIANGLE     = 3'd2,
    CMD_FILL_CIRCLE  = 3'd3,
    CMD_CLEAR_AREA   = 3'd4,
    CMD_CLEAR_CIRCLE = 3'd5,
    CMD_CLEAR_ALL    = 3'd6,
    CMD_DUMP         = 3'd7
  } cmd_t;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic rd_en;
    logic wr_en;
    logic out_load;
    logic out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/bpde_ctrl.sv @@
// sequencer that walks the canvas rows for each request but clear all
`default_nettype none
module bpde_ctrl import bpde_pkg::*; #(
  parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
  localparam int RA_W = $clog2(CANVAS_ROWS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  command,
  input  wire dp_stat_t          stat,
  output dp_cmd_t                cmd,
  output logic      [RA_W-1:0]   raddr,
  output logic      [RA_W-1:0]   row1
);

  localparam logic [RA_W-1:0] LAST_ROW = RA_W'(CANVAS_ROWS - 1);

  typedef enum logic [1:0] {
    IDLE,
    DRAW,
    DUMP
  } state_t;

  state_t            state;
  logic [RA_W-1:0]   y;
  logic              sent;
  logic              p1;
  logic              accept;
  logic              issue;

  always_comb begin
    accept = in_valid && (state == IDLE);
    issue  = ((state == DRAW) && !sent) ||
             ((state == DUMP) && !sent && (!p1 || stat.out_free));
    cmd.load      = accept;
    cmd.clear_all = accept && (cmd_t'(command) == CMD_CLEAR_ALL);
    cmd.rd_en     = issue;
    cmd.wr_en     = (state == DRAW) && p1;
    cmd.out_load  = (state == DUMP) && p1 && stat.out_free;
    cmd.out_last  = (row1 == LAST_ROW);
    in_stall      = (state != IDLE);
    raddr         = y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      y     <= '0;
      sent  <= 1'b0;
      p1    <= 1'b0;
      row1  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            y    <= '0;
            sent <= 1'b0;
            p1   <= 1'b0;
            if (cmd_t'(command) == CMD_DUMP) begin
              state <= DUMP;
            end else if (cmd_t'(command) != CMD_CLEAR_ALL) begin
              state <= DRAW;
            end
          end
        end
        DRAW: begin
          p1 <= issue;
          if (issue) begin
            row1 <= y;
            if (y == LAST_ROW) begin
              sent <= 1'b1;
            end else begin
              y <= y + RA_W'(1);
            end
          end
          if (p1 && (row1 == LAST_ROW)) begin
            state <= IDLE;
          end
        end
        DUMP: begin
          p1 <= issue || (p1 && !stat.out_free);
          if (issue) begin
            row1 <= y;
            if (y == LAST_ROW) begin
              sent <= 1'b1;
            end else begin
              y <= y + RA_W'(1);
            end
          end
          if (cmd.out_load && (row1 == LAST_ROW)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wr_only_in_draw: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (state == DRAW))
    else $error("row write outside a draw sweep");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.rd_en && !cmd.wr_en && !p1)
    else $error("request taken while a sweep is in flight");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("dump row loaded over a waiting result");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (state == IDLE))
    else $error("dump did not finish after the last row");

  a_draw_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.out_last) |=> (state == IDLE) && !p1)
    else $error("draw sweep did not finish after the last row");
`endif

endmodule
`default_nettype wire

@@ hdl/bpde_dp.sv @@
// canvas memory, per-row shape masks and dump output register
`default_nettype none
module bpde_dp import bpde_pkg::*; #(
  parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
  parameter int CANVAS_COLS = CANVAS_COLS_DEF,
  localparam int RA_W = $clog2(CANVAS_ROWS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dp_cmd_t                cmd,
  input  wire logic [RA_W-1:0]        raddr,
  input  wire logic [RA_W-1:0]        row1,
  input  wire logic [CMD_W-1:0]       command,
  input  wire logic [COORD_W-1:0]     row,
  input  wire logic [COORD_W-1:0]     col,
  input  wire logic [COORD_W-1:0]     row2,
  input  wire logic [COORD_W-1:0]     col2,
  input  wire logic [SIZE_W-1:0]      height,
  input  wire logic [SIZE_W-1:0]      width,
  input  wire logic [SIZE_W-1:0]      radius,
  output dp_stat_t                    stat,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [ROW_IDX_W-1:0]        row_index,
  output logic [ROW_BITS_W-1:0]       row_bits,
  output logic                        last
);

  localparam int DY_W  = (RA_W > COORD_W) ? RA_W : COORD_W;
  localparam int REM_W = ((LIM_W > 2 * DY_W) ? LIM_W : 2 * DY_W) + 1;

  // request fields
  cmd_t                 cmd_q;
  logic [COORD_W-1:0]   r_q;
  logic [COORD_W-1:0]   c_q;
  logic [COORD_W-1:0]   r2_q;
  logic [COORD_W-1:0]   c2_q;
  logic [SIZE_W-1:0]    h_q;
  logic [SIZE_W-1:0]    w_q;
  logic [LIM_W-1:0]     lim_q;

  // canvas
  logic [CANVAS_COLS-1:0] mem [CANVAS_ROWS];
  logic [CANVAS_ROWS-1:0] valid;
  logic [CANVAS_COLS-1:0] rdata;
  logic                   rvalid;
  logic signed [REM_W-1:0] rem;

  logic [EXT_W-1:0]       ya;
  logic [EXT_W-1:0]       dy_abs;
  logic [2*DY_W-1:0]      dysq;
  logic signed [REM_W-1:0] rem_next;

  logic [EXT_W-1:0] ye, re, ce, hb, wb, bot, right, tri_i;
  logic [EXT_W-1:0] lo_c, hi_c, lo_r, hi_r;
  logic             h_nz, w_nz, in_rows, edge_row, line_h, line_v;
  logic             row_hit, line_v_rows;

  logic [EXT_W-1:0]       xe     [CANVAS_COLS];
  logic [DX_W-1:0]        dx_abs [CANVAS_COLS];
  logic [2*DX_W-1:0]      dxsq   [CANVAS_COLS];
  logic [CANVAS_COLS-1:0] in_cols;
  logic [CANVAS_COLS-1:0] m_rect, m_line, m_tri, m_disc, m_area, mask;
  logic [CANVAS_COLS-1:0] old, wdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= cmd_t'(command);
      r_q   <= row;
      c_q   <= col;
      r2_q  <= row2;
      c2_q  <= col2;
      h_q   <= height;
      w_q   <= width;
      lim_q <= LIM_W'(radius) * LIM_W'(radius);
    end
  end

  // squared row distance, folded into the circle budget at read time
  always_comb begin
    ya       = EXT_W'(raddr);
    dy_abs   = (ya >= EXT_W'(r_q)) ? (ya - EXT_W'(r_q)) : (EXT_W'(r_q) - ya);
    dysq     = (2*DY_W)'(DY_W'(dy_abs)) * (2*DY_W)'(DY_W'(dy_abs));
    rem_next = $signed(REM_W'(lim_q)) - $signed(REM_W'(dysq));
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata  <= mem[raddr];
      rvalid <= valid[raddr];
      rem    <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[row1] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clear_all) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[row1] <= 1'b1;
    end
  end

  // row-level terms
  always_comb begin
    ye       = EXT_W'(row1);
    re       = EXT_W'(r_q);
    ce       = EXT_W'(c_q);
    hb       = EXT_W'(h_q);
    wb       = EXT_W'(w_q);
    bot      = re + hb - EXT_W'(1);
    right    = ce + wb - EXT_W'(1);
    h_nz     = (h_q != '0);
    w_nz     = (w_q != '0);
    in_rows  = (ye >= re) && (ye <= bot);
    edge_row = (ye == re) || (ye == bot);
    row_hit  = h_nz && in_rows;
    tri_i    = ye - re;
    lo_c     = EXT_W'((c_q < c2_q) ? c_q : c2_q);
    hi_c     = EXT_W'((c_q < c2_q) ? c2_q : c_q);
    lo_r     = EXT_W'((r_q < r2_q) ? r_q : r2_q);
    hi_r     = EXT_W'((r_q < r2_q) ? r2_q : r_q);
    line_h   = (r_q == r2_q) && (ye == re);
    line_v_rows = (ye >= lo_r) && (ye <= hi_r);
    line_v   = (r_q != r2_q) && (c_q == c2_q) && line_v_rows;
  end

  // per-column masks
  always_comb begin
    for (int x = 0; x < CANVAS_COLS; x++) begin
      xe[x]      = EXT_W'(x);
      dx_abs[x]  = DX_W'((xe[x] >= ce) ? (xe[x] - ce) : (ce - xe[x]));
      dxsq[x]    = (2*DX_W)'(dx_abs[x]) * (2*DX_W)'(dx_abs[x]);
      in_cols[x] = (xe[x] >= ce) && (xe[x] <= right);
      m_rect[x]  = row_hit && w_nz &&
                   (edge_row ? in_cols[x] : ((xe[x] == ce) || (xe[x] == right)));
      m_line[x]  = (line_h && (xe[x] >= lo_c) && (xe[x] <= hi_c)) ||
                   (line_v && (xe[x] == ce));
      m_tri[x]   = row_hit &&
                   (((xe[x] + tri_i) == ce) || (xe[x] == (ce + tri_i)) ||
                    ((ye == bot) && ((xe[x] + hb) >= (ce + EXT_W'(1))) &&
                     ((xe[x] + EXT_W'(1)) <= (ce + hb))));
      m_disc[x]  = !rem[REM_W-1] && (REM_W'(dxsq[x]) <= $unsigned(rem));
      m_area[x]  = row_hit && w_nz && in_cols[x];
    end
  end

  always_comb begin
    old = rvalid ? rdata : '0;
    unique case (cmd_q) inside
      CMD_RECT:                          mask = m_rect;
      CMD_LINE:                          mask = m_line;
      CMD_TRIANGLE:                      mask = m_tri;
      CMD_FILL_CIRCLE, CMD_CLEAR_CIRCLE: mask = m_disc;
      CMD_CLEAR_AREA:                    mask = m_area;
      default:                           mask = '0;
    endcase
    unique case (cmd_q) inside
      CMD_CLEAR_AREA, CMD_CLEAR_CIRCLE: wdata = old & ~mask;
      default:                          wdata = old | mask;
    endcase
  end

  // dump output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      row_index <= ROW_IDX_W'(row1);
      row_bits  <= ROW_BITS_W'(old);
      last      <= cmd.out_last;
    end
  end

  assign stat.out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

@@ hdl/bitmap_primitive_drawing_engine.sv @@
// top level of the one-bit-per-pixel bitmap drawing engine
`default_nettype none
// Holds a CANVAS_ROWS by CANVAS_COLS one-bit canvas in a row memory with one
// read and one write port and applies one drawing request at a time. Every
// shape request and every clear but clear all sweeps all rows, one
// read-modify-write of a whole row per cycle, reading the next row while the
// previous one is written back. Clear all needs no sweep: the per-row valid
// flags are dropped when it is taken, and the same flags make the canvas
// blank right after reset with no clearing pass. Dump reads the rows in
// order into the output register and emits CANVAS_ROWS results, the last
// one flagged; it runs at one row per cycle when the output side does not
// stall. Pixels outside the canvas are ignored.
module bitmap_primitive_drawing_engine import bpde_pkg::*; #(
  parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
  parameter int CANVAS_COLS = CANVAS_COLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [CMD_W-1:0]       command,
  input  wire logic [COORD_W-1:0]     row,
  input  wire logic [COORD_W-1:0]     col,
  input  wire logic [COORD_W-1:0]     row2,
  input  wire logic [COORD_W-1:0]     col2,
  input  wire logic [SIZE_W-1:0]      height,
  input  wire logic [SIZE_W-1:0]      width,
  input  wire logic [SIZE_W-1:0]      radius,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [ROW_IDX_W-1:0]        row_index,
  output logic [ROW_BITS_W-1:0]       row_bits,
  output logic                        last
);

  localparam int RA_W = $clog2(CANVAS_ROWS);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [RA_W-1:0]  raddr;
  logic [RA_W-1:0]  row1;

  bpde_ctrl #(
    .CANVAS_ROWS (CANVAS_ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd),
    .raddr    (raddr),
    .row1     (row1)
  );

  bpde_dp #(
    .CANVAS_ROWS (CANVAS_ROWS),
    .CANVAS_COLS (CANVAS_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .raddr     (raddr),
    .row1      (row1),
    .command   (command),
    .row       (row),
    .col       (col),
    .row2      (row2),
    .col2      (col2),
    .height    (height),
    .width     (width),
    .radius    (radius),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_index (row_index),
    .row_bits  (row_bits),
    .last      (last)
  );

endmodule
`default_nettype wire

@@ dv/tb_bitmap_primitive_drawing_engine.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the bitmap drawing engine: random requests, canvas predictor, dump check
module tb_bitmap_primitive_drawing_engine;
  import bpde_pkg::*;

  localparam int CANVAS_ROWS = CANVAS_ROWS_DEF;
  localparam int CANVAS_COLS = CANVAS_COLS_DEF;
  localparam int RANDOM_REQS = 233;

  typedef struct {
    cmd_t                command;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row2;
    logic [COORD_W-1:0]  col2;
    logic [SIZE_W-1:0]   height;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   radius;
  } draw_req_t;

  typedef struct {
    logic [ROW_IDX_W-1:0]  idx;
    logic [ROW_BITS_W-1:0] bits;
    logic                  last;
  } dump_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      command = '0;
  logic [COORD_W-1:0]    row = '0;
  logic [COORD_W-1:0]    col = '0;
  logic [COORD_W-1:0]    row2 = '0;
  logic [COORD_W-1:0]    col2 = '0;
  logic [SIZE_W-1:0]     height = '0;
  logic [SIZE_W-1:0]     width = '0;
  logic [SIZE_W-1:0]     radius = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_IDX_W-1:0]  row_index;
  logic [ROW_BITS_W-1:0] row_bits;
  logic                  last;

  logic [CANVAS_COLS-1:0] canvas [CANVAS_ROWS];
  draw_req_t pending_reqs [$];
  dump_row_t rows_due [$];
  draw_req_t next_req;
  draw_req_t taken_req;
  dump_row_t want;
  bit        req_taken = 1'b0;
  int        in_wait = 0;
  int        out_wait = 0;
  int        reqs_taken = 0;
  int        rows_checked = 0;
  int        errors = 0;
  int        cmd_seen [8];

  bitmap_primitive_drawing_engine #(
    .CANVAS_ROWS(CANVAS_ROWS),
    .CANVAS_COLS(CANVAS_COLS)
  ) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .row(row), .col(col), .row2(row2), .col2(col2),
    .height(height), .width(width), .radius(radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_index(row_index), .row_bits(row_bits), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void paint(int r, int c, bit on);
    if (r < 0 || r >= CANVAS_ROWS || c < 0 || c >= CANVAS_COLS) return;
    canvas[r][c] = on;
  endfunction

  // updates the canvas copy and queues the rows a dump should return
  function automatic void apply_request(draw_req_t q);
    int r, c, r2, c2, h, w, lim, lo, hi, i, j;
    dump_row_t d;
    r = int'(q.row);
    c = int'(q.col);
    r2 = int'(q.row2);
    c2 = int'(q.col2);
    h = int'(q.height);
    w = int'(q.width);
    lim = int'(q.radius) * int'(q.radius);
    case (q.command)
      CMD_RECT: begin
        if (h > 0 && w > 0) begin
          for (i = c; i < c + w; i++) begin
            paint(r, i, 1'b1);
            paint(r + h - 1, i, 1'b1);
          end
          for (i = r; i < r + h; i++) begin
            paint(i, c, 1'b1);
            paint(i, c + w - 1, 1'b1);
          end
        end
      end
      CMD_LINE: begin
        if (r == r2) begin
          lo = (c < c2) ? c : c2;
          hi = (c < c2) ? c2 : c;
          for (i = lo; i <= hi; i++) paint(r, i, 1'b1);
        end else if (c == c2) begin
          lo = (r < r2) ? r : r2;
          hi = (r < r2) ? r2 : r;
          for (i = lo; i <= hi; i++) paint(i, c, 1'b1);
        end
      end
      CMD_TRIANGLE: begin
        if (h > 0) begin
          for (i = 0; i < h; i++) begin
            paint(r + i, c - i, 1'b1);
            paint(r + i, c + i, 1'b1);
          end
          for (i = c - h + 1; i <= c + h - 1; i++) paint(r + h - 1, i, 1'b1);
        end
      end
      CMD_FILL_CIRCLE, CMD_CLEAR_CIRCLE: begin
        for (i = 0; i < CANVAS_ROWS; i++)
          for (j = 0; j < CANVAS_COLS; j++)
            if ((j - c) * (j - c) + (i - r) * (i - r) <= lim)
              paint(i, j, q.command == CMD_FILL_CIRCLE);
      end
      CMD_CLEAR_AREA: begin
        if (h > 0 && w > 0)
          for (i = r; i < r + h; i++)
            for (j = c; j < c + w; j++) paint(i, j, 1'b0);
      end
      CMD_CLEAR_ALL: begin
        for (i = 0; i < CANVAS_ROWS; i++) canvas[i] = '0;
      end
      default: begin
        for (i = 0; i < CANVAS_ROWS; i++) begin
          d.idx = ROW_IDX_W'(i);
          d.bits = ROW_BITS_W'(canvas[i]);
          d.last = (i == CANVAS_ROWS - 1);
          rows_due.push_back(d);
        end
      end
    endcase
  endfunction

  task automatic push_req(cmd_t cmd, int r, int c, int r2, int c2, int h, int w, int rad);
    draw_req_t q;
    q.command = cmd;
    q.row = COORD_W'(r);
    q.col = COORD_W'(c);
    q.row2 = COORD_W'(r2);
    q.col2 = COORD_W'(c2);
    q.height = SIZE_W'(h);
    q.width = SIZE_W'(w);
    q.radius = SIZE_W'(rad);
    pending_reqs.push_back(q);
  endtask

  // request side: take, predict
  always @(posedge clk) begin
    req_taken = !rst && in_valid && !in_stall;
    if (req_taken) begin
      taken_req.command = cmd_t'(command);
      taken_req.row = row;
      taken_req.col = col;
      taken_req.row2 = row2;
      taken_req.col2 = col2;
      taken_req.height = height;
      taken_req.width = width;
      taken_req.radius = radius;
      apply_request(taken_req);
      cmd_seen[command]++;
      reqs_taken++;
      in_wait = draw_wait((reqs_taken / 40) % 3 == 2);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // stalled request holds
    end else if (in_wait > 0) begin
      in_valid <= 1'b0;
      in_wait--;
    end else if (pending_reqs.size() > 0) begin
      next_req = pending_reqs.pop_front();
      command <= next_req.command;
      row <= next_req.row;
      col <= next_req.col;
      row2 <= next_req.row2;
      col2 <= next_req.col2;
      height <= next_req.height;
      width <= next_req.width;
      radius <= next_req.radius;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // dump side: stall, compare
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_wait > 0) begin
      out_stall <= 1'b1;
      out_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (rows_due.size() == 0) begin
        $error("dump row %0d arrived with no dump pending", row_index);
        errors++;
      end else begin
        want = rows_due.pop_front();
        if (row_index !== want.idx) begin
          $error("row_index: expected %0d, got %0d", want.idx, row_index);
          errors++;
        end
        if (row_bits !== want.bits) begin
          $error("row_bits (row %0d): expected %h, got %h", want.idx, want.bits, row_bits);
          errors++;
        end
        if (last !== want.last) begin
          $error("last (row %0d): expected %0b, got %0b", want.idx, want.last, last);
          errors++;
        end
      end
      rows_checked++;
      out_wait = draw_wait((rows_checked / 64) % 3 == 2);
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    draw_req_t q;
    int n, pick;
    foreach (canvas[i]) canvas[i] = '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    out_wait = $urandom_range(0, 5);

    // blank canvas, border clipping, zero sizes
    push_req(CMD_DUMP, 31, 31, 31, 31, 63, 63, 63);
    push_req(CMD_RECT, 0, 0, 17, 9, 32, 32, 0);
    push_req(CMD_RECT, 30, 30, 0, 0, 5, 5, 63);
    push_req(CMD_RECT, 5, 5, 31, 31, 0, 5, 21);
    push_req(CMD_RECT, 5, 5, 0, 0, 5, 0, 42);
    push_req(CMD_DUMP, 0, 0, 0, 0, 0, 0, 0);
    // lines: reversed ends, diagonal, single point
    push_req(CMD_LINE, 3, 31, 3, 0, 32, 32, 63);
    push_req(CMD_LINE, 31, 5, 0, 5, 0, 0, 0);
    push_req(CMD_LINE, 1, 1, 5, 7, 20, 20, 20);
    push_req(CMD_LINE, 10, 10, 10, 10, 1, 1, 1);
    push_req(CMD_DUMP, 12, 12, 12, 12, 12, 12, 12);
    // triangles clipped on both sides and at the bottom
    push_req(CMD_CLEAR_ALL, 31, 31, 31, 31, 63, 63, 63);
    push_req(CMD_TRIANGLE, 2, 2, 31, 0, 10, 0, 0);
    push_req(CMD_TRIANGLE, 9, 9, 0, 0, 0, 31, 31);
    push_req(CMD_TRIANGLE, 20, 31, 7, 7, 32, 1, 1);
    // circles: zero radius, corner, full canvas
    push_req(CMD_FILL_CIRCLE, 16, 16, 3, 3, 9, 9, 0);
    push_req(CMD_FILL_CIRCLE, 0, 31, 1, 1, 1, 1, 7);
    push_req(CMD_DUMP, 5, 5, 5, 5, 5, 5, 5);
    push_req(CMD_CLEAR_CIRCLE, 16, 16, 0, 0, 0, 0, 5);
    push_req(CMD_CLEAR_AREA, 25, 25, 0, 0, 32, 32, 0);
    push_req(CMD_CLEAR_AREA, 0, 0, 0, 0, 0, 32, 0);
    push_req(CMD_DUMP, 0, 0, 0, 0, 0, 0, 0);
    push_req(CMD_FILL_CIRCLE, 31, 0, 0, 0, 0, 0, 63);
    push_req(CMD_CLEAR_CIRCLE, 31, 0, 0, 0, 0, 0, 20);
    push_req(CMD_CLEAR_AREA, 0, 0, 0, 0, 32, 32, 0);
    push_req(CMD_DUMP, 31, 31, 31, 31, 32, 32, 63);

    for (n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      q.command = CMD_DUMP;
      q.row = COORD_W'($urandom);
      q.col = COORD_W'($urandom);
      q.row2 = COORD_W'($urandom);
      q.col2 = COORD_W'($urandom);
      q.height = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 32))
                                             : SIZE_W'($urandom_range(0, 12));
      q.width = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 32))
                                            : SIZE_W'($urandom_range(0, 12));
      q.radius = ($urandom_range(0, 4) == 0) ? SIZE_W'($urandom_range(0, 63))
                                             : SIZE_W'($urandom_range(0, 12));
      if (pick < 15) q.command = CMD_DUMP;
      else if (pick < 18) q.command = CMD_CLEAR_ALL;
      else if (pick < 32) q.command = CMD_RECT;
      else if (pick < 48) q.command = CMD_LINE;
      else if (pick < 60) q.command = CMD_TRIANGLE;
      else if (pick < 72) q.command = CMD_FILL_CIRCLE;
      else if (pick < 84) q.command = CMD_CLEAR_AREA;
      else q.command = CMD_CLEAR_CIRCLE;
      if (q.command == CMD_LINE) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) q.row2 = q.row;
        else if (pick < 8) q.col2 = q.col;
      end
      pending_reqs.push_back(q);
    end
    push_req(CMD_DUMP, 0, 0, 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid || rows_due.size() != 0) @(negedge clk);
    repeat (2 * CANVAS_ROWS + 8) @(negedge clk);
    if (rows_due.size() != 0) begin
      $error("%0d dump rows never arrived", rows_due.size());
      errors++;
    end

    $display("%0d requests taken: rect %0d, line %0d, triangle %0d, fill circle %0d,",
             reqs_taken, cmd_seen[CMD_RECT], cmd_seen[CMD_LINE], cmd_seen[CMD_TRIANGLE],
             cmd_seen[CMD_FILL_CIRCLE]);
    $display("clear area %0d, clear circle %0d, clear all %0d, dump %0d; %0d rows compared",
             cmd_seen[CMD_CLEAR_AREA], cmd_seen[CMD_CLEAR_CIRCLE], cmd_seen[CMD_CLEAR_ALL],
             cmd_seen[CMD_DUMP], rows_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bpde_pkg.sv
hdl/bpde_ctrl.sv
hdl/bpde_dp.sv
hdl/bitmap_primitive_drawing_engine.sv
dv/tb_bitmap_primitive_drawing_engine.sv
